[src/lpg_pkg.sv]
// Shared types, codes and the breathe duty table of the LED pattern generator.
package lpg_pkg;

   localparam int IDX_BITS    = 7;
   localparam int MS_BITS     = 16;
   localparam int DUTY_BITS   = 7;
   localparam int ROM_LEN     = 65;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [2:0] CMD_TICK    = 3'd0;
   localparam logic [2:0] CMD_WRITE   = 3'd1;
   localparam logic [2:0] CMD_TOGGLE  = 3'd2;
   localparam logic [2:0] CMD_READ    = 3'd3;
   localparam logic [2:0] CMD_BREATHE = 3'd4;
   localparam logic [2:0] CMD_BLINK   = 3'd5;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_NODEV   = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_LED_BOUND    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INVERT_DUTY  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLINK_ON     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLINK_OFF    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BREATHE_STEP = 3'd4;

   localparam logic [DUTY_BITS-1:0] DUTY_FULL = 7'd100;

   localparam logic [DUTY_BITS-1:0] DUTY_ROM [ROM_LEN] = '{
      7'd0,  7'd0,  7'd1,  7'd2,  7'd4,  7'd6,  7'd8,  7'd11, 7'd15, 7'd18, 7'd22,
      7'd26, 7'd31, 7'd35, 7'd40, 7'd45, 7'd50, 7'd55, 7'd60, 7'd65, 7'd69, 7'd74,
      7'd78, 7'd82, 7'd85, 7'd89, 7'd92, 7'd94, 7'd96, 7'd98, 7'd99, 7'd100,
      7'd100, 7'd100, 7'd99, 7'd98, 7'd96, 7'd94, 7'd92, 7'd89, 7'd85, 7'd82,
      7'd78, 7'd74, 7'd69, 7'd65, 7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
      7'd31, 7'd26, 7'd22, 7'd18, 7'd15, 7'd11, 7'd8,  7'd6,  7'd4,  7'd2,
      7'd1,  7'd0,  7'd0
   };

   typedef enum logic [2:0] {
      MODE_STEADY  = 3'b001,
      MODE_BREATHE = 3'b010,
      MODE_BLINK   = 3'b100
   } mode_type;

   typedef struct packed {
      logic               led_bound;
      logic               invert_duty;
      logic [MS_BITS-1:0] blink_on_ms;
      logic [MS_BITS-1:0] blink_off_ms;
      logic [MS_BITS-1:0] breathe_step_ms;
   } cfg_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       write_value;
   } item_type;

   typedef struct packed {
      logic [1:0]           status;
      logic                 duty_update;
      logic [DUTY_BITS-1:0] raw_duty_percent;
      logic                 led_on;
   } result_type;

endpackage

[src/lpg_csr.sv]
// Configuration register file of the LED pattern generator.
module lpg_csr
   import lpg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [MS_BITS-1:0]      csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LED_BOUND:    cfg_in.led_bound       = csr_wdata[0];
            CSR_INVERT_DUTY:  cfg_in.invert_duty     = csr_wdata[0];
            CSR_BLINK_ON:     cfg_in.blink_on_ms     = csr_wdata;
            CSR_BLINK_OFF:    cfg_in.blink_off_ms    = csr_wdata;
            CSR_BREATHE_STEP: cfg_in.breathe_step_ms = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.led_bound       <= 1'b1;
         cfg_ff.invert_duty     <= 1'b0;
         cfg_ff.blink_on_ms     <= 16'd500;
         cfg_ff.blink_off_ms    <= 16'd500;
         cfg_ff.breathe_step_ms <= 16'd31;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/lpg_engine.sv]
// Pattern state registers and the per-item next-state and result logic.
module lpg_engine
   import lpg_pkg::*;
#(
   parameter int BREATHE_STEPS = 65,
   parameter int TIMER_BITS    = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(BREATHE_STEPS - 1);
   localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

   mode_type              mode_ff, mode_in;
   logic [IDX_BITS-1:0]   index_ff, index_in;
   logic                  phase_ff, phase_in;
   logic [TIMER_BITS-1:0] rem_ff, rem_in;
   logic                  lit_ff, lit_in;

   logic                  drive_en;
   logic [DUTY_BITS-1:0]  drive_level;
   logic [DUTY_BITS-1:0]  rom_level;
   logic [MS_BITS-1:0]    load_ms;
   logic [TIMER_BITS-1:0] load_val;
   logic [1:0]            status;

   // Countdown reload saturates when the timer is narrower than the register.
   always_comb begin
      if (32'(load_ms) > TIMER_MAX) begin
         load_val = TIMER_BITS'(TIMER_MAX);
      end else begin
         load_val = TIMER_BITS'(32'(load_ms));
      end
   end

   assign rom_level = (32'(index_ff) < 32'(ROM_LEN)) ? DUTY_ROM[index_ff] : '0;

   always_comb begin
      mode_in     = mode_ff;
      index_in    = index_ff;
      phase_in    = phase_ff;
      rem_in      = rem_ff;
      drive_en    = 1'b0;
      drive_level = '0;
      load_ms     = cfg.breathe_step_ms;
      status      = STATUS_OK;
      case (item.cmd)
         CMD_TICK: begin
            unique case (mode_ff)
               MODE_STEADY: mode_in = MODE_STEADY;
               MODE_BREATHE: begin
                  if (rem_ff > TIMER_BITS'(1)) begin
                     rem_in = rem_ff - TIMER_BITS'(1);
                  end else begin
                     index_in    = (index_ff == LAST_IDX) ? '0 : index_ff + IDX_BITS'(1);
                     load_ms     = cfg.breathe_step_ms;
                     rem_in      = load_val;
                     drive_en    = 1'b1;
                     drive_level = rom_level;
                  end
               end
               MODE_BLINK: begin
                  if (rem_ff > TIMER_BITS'(1)) begin
                     rem_in = rem_ff - TIMER_BITS'(1);
                  end else begin
                     phase_in    = !phase_ff;
                     load_ms     = phase_ff ? cfg.blink_off_ms : cfg.blink_on_ms;
                     rem_in      = load_val;
                     drive_en    = 1'b1;
                     drive_level = phase_ff ? '0 : DUTY_FULL;
                  end
               end
               default: mode_in = MODE_STEADY;
            endcase
         end
         CMD_WRITE: begin
            mode_in     = MODE_STEADY;
            drive_en    = 1'b1;
            drive_level = item.write_value ? DUTY_FULL : '0;
         end
         CMD_TOGGLE: begin
            mode_in     = MODE_STEADY;
            drive_en    = 1'b1;
            drive_level = lit_ff ? '0 : DUTY_FULL;
         end
         CMD_BREATHE: begin
            mode_in  = MODE_BREATHE;
            index_in = '0;
            phase_in = 1'b0;
            rem_in   = '0;
            drive_en = 1'b1;
         end
         CMD_BLINK: begin
            if (cfg.blink_on_ms == '0 || cfg.blink_off_ms == '0) begin
               status = STATUS_INVALID;
            end else begin
               mode_in     = MODE_BLINK;
               index_in    = '0;
               phase_in    = 1'b1;
               load_ms     = cfg.blink_on_ms;
               rem_in      = load_val;
               drive_en    = 1'b1;
               drive_level = DUTY_FULL;
            end
         end
         default: status = STATUS_OK;
      endcase
   end

   // An unbound indicator still advances the pattern but issues no duty.
   always_comb begin
      lit_in                  = lit_ff;
      result.status           = status;
      result.duty_update      = 1'b0;
      result.raw_duty_percent = '0;
      if (drive_en) begin
         if (!cfg.led_bound) begin
            result.status = STATUS_NODEV;
         end else begin
            lit_in                  = (drive_level != '0);
            result.duty_update      = 1'b1;
            result.raw_duty_percent = cfg.invert_duty ? DUTY_FULL - drive_level : drive_level;
         end
      end
      result.led_on = lit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_STEADY;
         index_ff <= '0;
         phase_ff <= 1'b0;
         rem_ff   <= '0;
         lit_ff   <= 1'b0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         index_ff <= index_in;
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
         lit_ff   <= lit_in;
      end
   end

endmodule

[src/led_pattern_generator.sv]
// Throughput: one item per cycle while rsp_tready does not stall the output; the input register and the result register
// form a two-stage pipeline, with the pattern state updated in the second stage.
// Reset (synchronous, active high) puts the engine in steady mode with the LED
// off, restores the default configuration and empties both stages.
// Configuration writes are taken every cycle.
module led_pattern_generator
   import lpg_pkg::*;
#(
   parameter int BREATHE_STEPS = 65,
   parameter int TIMER_BITS    = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,  // cmd[2:0], write_value[3], zero[7:4]
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [15:0]             rsp_tdata,  // status[1:0], duty_update[2],
                                               // raw_duty_percent[9:3], led_on[10], zero[15:11]
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [MS_BITS-1:0]      csr_wdata
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       fire;

   lpg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lpg_engine #(
      .BREATHE_STEPS (BREATHE_STEPS),
      .TIMER_BITS    (TIMER_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign csr_ready  = 1'b1;
   assign fire       = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || fire;

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      if (req_tready) begin
         item_valid_in     = req_tvalid;
         item_in.cmd       = req_tdata[2:0];
         item_in.write_value = req_tdata[3];
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff.led_on, rsp_ff.raw_duty_percent,
                        rsp_ff.duty_update, rsp_ff.status};

endmodule
